// ----- rtl/hsv_to_rgb_converter_unit_assert.svh -----
// Assertion macros used by the checker of this block.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_ASSERT_SVH

// Check a property at every rising clock edge, skip it while reset is held.
`define HSV2RGB_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising clock edge, reset included.
`define HSV2RGB_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/hsv2rgb_pkg.sv -----
package hsv2rgb_pkg;

    localparam int CH_W       = 8;
    localparam int PROD_W     = 2 * CH_W;
    localparam int WIDE_W     = 3 * CH_W;
    localparam int SCALED_W   = CH_W + 3;
    localparam int FULL       = 255;
    localparam int FULL_SQ    = FULL * FULL;
    localparam int SECTORS    = 6;
    localparam int PIPE_DEPTH = 5;

    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [WIDE_W-1:0] t_wide;

    // Sixths of the hue circle, named by the two primaries they span.
    typedef enum logic [2:0] {
        SEC_RED_YEL,
        SEC_YEL_GRN,
        SEC_GRN_CYN,
        SEC_CYN_BLU,
        SEC_BLU_MAG,
        SEC_MAG_RED
    } t_sector;

endpackage

// ----- rtl/hsv2rgb_hsv_if.sv -----
interface hsv2rgb_hsv_if;
    logic                 valid;
    logic                 ready;
    hsv2rgb_pkg::t_chan   hue;
    hsv2rgb_pkg::t_chan   saturation;
    hsv2rgb_pkg::t_chan   value;

    modport source (output valid, output hue, output saturation, output value, input ready);
    modport sink   (input valid, input hue, input saturation, input value, output ready);
endinterface

// ----- rtl/hsv2rgb_rgb_if.sv -----
interface hsv2rgb_rgb_if;
    logic                 valid;
    logic                 ready;
    hsv2rgb_pkg::t_chan   red;
    hsv2rgb_pkg::t_chan   green;
    hsv2rgb_pkg::t_chan   blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ----- rtl/hsv2rgb_datapath.sv -----
module hsv2rgb_datapath (
    input  logic                 i_clk,
    input  logic                 i_advance,
    input  hsv2rgb_pkg::t_chan   i_hue,
    input  hsv2rgb_pkg::t_chan   i_saturation,
    input  hsv2rgb_pkg::t_chan   i_value,
    output hsv2rgb_pkg::t_chan   o_red,
    output hsv2rgb_pkg::t_chan   o_green,
    output hsv2rgb_pkg::t_chan   o_blue
);

    localparam int SW = hsv2rgb_pkg::SCALED_W;
    localparam int PW = hsv2rgb_pkg::PROD_W;
    localparam int WW = hsv2rgb_pkg::WIDE_W;
    localparam int CW = hsv2rgb_pkg::CH_W;

    // Stage 1: sector and fraction
    hsv2rgb_pkg::t_sector r_s1_sector, n_s1_sector;
    hsv2rgb_pkg::t_chan   r_s1_frac, n_s1_frac;
    hsv2rgb_pkg::t_chan   r_s1_sat, r_s1_val;

    // Stage 2: numerators of p, q and t
    hsv2rgb_pkg::t_sector r_s2_sector;
    hsv2rgb_pkg::t_chan   r_s2_val;
    hsv2rgb_pkg::t_prod   r_s2_pn, r_s2_qn, r_s2_tn;
    hsv2rgb_pkg::t_prod   n_s2_pn, n_s2_qn, n_s2_tn;

    // Stage 3: scaled q and t, first guess of p
    hsv2rgb_pkg::t_sector r_s3_sector;
    hsv2rgb_pkg::t_chan   r_s3_val, r_s3_pe, n_s3_pe;
    hsv2rgb_pkg::t_prod   r_s3_pn;
    hsv2rgb_pkg::t_wide   r_s3_qm, r_s3_tm, n_s3_qm, n_s3_tm;

    // Stage 4: p settled, first guess of q and t
    hsv2rgb_pkg::t_sector r_s4_sector;
    hsv2rgb_pkg::t_chan   r_s4_val, r_s4_p, n_s4_p;
    hsv2rgb_pkg::t_chan   r_s4_qe, r_s4_te, n_s4_qe, n_s4_te;
    hsv2rgb_pkg::t_wide   r_s4_qm, r_s4_tm;

    // Stage 5: channel outputs
    hsv2rgb_pkg::t_chan   r_red, r_green, r_blue;
    hsv2rgb_pkg::t_chan   n_red, n_green, n_blue;
    hsv2rgb_pkg::t_chan   w_q, w_t;

    logic [SW-1:0] w_scaled;
    logic [SW-1:0] w_frac_full;
    logic [PW-1:0] w_p_back;
    logic [WW-1:0] w_q_back, w_t_back, w_q_rem, w_t_rem;
    logic [WW-1:0] w_q_sum, w_t_sum;
    logic [PW-1:0] w_p_sum;

    // 6*hue split into sector and remainder; full-scale hue wraps to sector 0.
    always_comb begin
        w_scaled    = SW'(i_hue) * SW'(hsv2rgb_pkg::SECTORS);
        n_s1_sector = hsv2rgb_pkg::SEC_RED_YEL;
        for (int k = 1; k < hsv2rgb_pkg::SECTORS; k++) begin
            if (w_scaled >= SW'(hsv2rgb_pkg::FULL * k)) begin
                n_s1_sector = hsv2rgb_pkg::t_sector'(3'(k));
            end
        end
        w_frac_full = w_scaled - SW'(n_s1_sector) * SW'(hsv2rgb_pkg::FULL);
        n_s1_frac   = CW'(w_frac_full);
        if (w_scaled >= SW'(hsv2rgb_pkg::FULL * hsv2rgb_pkg::SECTORS)) begin
            n_s1_sector = hsv2rgb_pkg::SEC_RED_YEL;
            n_s1_frac   = '0;
        end
    end

    always_comb begin
        n_s2_pn = PW'(r_s1_val) * PW'(CW'(hsv2rgb_pkg::FULL) - r_s1_sat);
        n_s2_qn = PW'(hsv2rgb_pkg::FULL_SQ) - PW'(r_s1_frac) * PW'(r_s1_sat);
        n_s2_tn = PW'(hsv2rgb_pkg::FULL_SQ)
                - PW'(CW'(hsv2rgb_pkg::FULL) - r_s1_frac) * PW'(r_s1_sat);
    end

    // x/255 ~ (x + x>>8) >> 8, low by at most one.
    always_comb begin
        n_s3_qm = WW'(r_s2_val) * WW'(r_s2_qn);
        n_s3_tm = WW'(r_s2_val) * WW'(r_s2_tn);
        w_p_sum = r_s2_pn + (r_s2_pn >> CW);
        n_s3_pe = CW'(w_p_sum >> CW);
    end

    // x/65025 ~ (x + x>>7) >> 16, low by at most one.
    always_comb begin
        w_p_back = (PW'(r_s3_pe) << CW) - PW'(r_s3_pe);
        n_s4_p   = r_s3_pe;
        if ((r_s3_pn - w_p_back) >= PW'(hsv2rgb_pkg::FULL)) begin
            n_s4_p = r_s3_pe + 1'b1;
        end
        w_q_sum  = r_s3_qm + (r_s3_qm >> 7);
        w_t_sum  = r_s3_tm + (r_s3_tm >> 7);
        n_s4_qe  = CW'(w_q_sum >> PW);
        n_s4_te  = CW'(w_t_sum >> PW);
    end

    // Fix the guesses: 65025*e = (e<<16) - (e<<9) + e.
    always_comb begin
        w_q_back = (WW'(r_s4_qe) << PW) - (WW'(r_s4_qe) << 9) + WW'(r_s4_qe);
        w_t_back = (WW'(r_s4_te) << PW) - (WW'(r_s4_te) << 9) + WW'(r_s4_te);
        w_q_rem  = r_s4_qm - w_q_back;
        w_t_rem  = r_s4_tm - w_t_back;
        w_q      = (w_q_rem >= WW'(hsv2rgb_pkg::FULL_SQ)) ? r_s4_qe + 1'b1 : r_s4_qe;
        w_t      = (w_t_rem >= WW'(hsv2rgb_pkg::FULL_SQ)) ? r_s4_te + 1'b1 : r_s4_te;
    end

    always_comb begin
        unique case (r_s4_sector)
            hsv2rgb_pkg::SEC_RED_YEL: begin
                n_red = r_s4_val; n_green = w_t;      n_blue = r_s4_p;
            end
            hsv2rgb_pkg::SEC_YEL_GRN: begin
                n_red = w_q;      n_green = r_s4_val; n_blue = r_s4_p;
            end
            hsv2rgb_pkg::SEC_GRN_CYN: begin
                n_red = r_s4_p;   n_green = r_s4_val; n_blue = w_t;
            end
            hsv2rgb_pkg::SEC_CYN_BLU: begin
                n_red = r_s4_p;   n_green = w_q;      n_blue = r_s4_val;
            end
            hsv2rgb_pkg::SEC_BLU_MAG: begin
                n_red = w_t;      n_green = r_s4_p;   n_blue = r_s4_val;
            end
            default: begin
                n_red = r_s4_val; n_green = r_s4_p;   n_blue = w_q;
            end
        endcase
    end

    // Advance every stage together; hold all of them on a stall.
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_s1_sector <= n_s1_sector;
            r_s1_frac   <= n_s1_frac;
            r_s1_sat    <= i_saturation;
            r_s1_val    <= i_value;

            r_s2_sector <= r_s1_sector;
            r_s2_val    <= r_s1_val;
            r_s2_pn     <= n_s2_pn;
            r_s2_qn     <= n_s2_qn;
            r_s2_tn     <= n_s2_tn;

            r_s3_sector <= r_s2_sector;
            r_s3_val    <= r_s2_val;
            r_s3_pn     <= r_s2_pn;
            r_s3_pe     <= n_s3_pe;
            r_s3_qm     <= n_s3_qm;
            r_s3_tm     <= n_s3_tm;

            r_s4_sector <= r_s3_sector;
            r_s4_val    <= r_s3_val;
            r_s4_p      <= n_s4_p;
            r_s4_qe     <= n_s4_qe;
            r_s4_te     <= n_s4_te;
            r_s4_qm     <= r_s3_qm;
            r_s4_tm     <= r_s3_tm;

            r_red       <= n_red;
            r_green     <= n_green;
            r_blue      <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ----- rtl/hsv_to_rgb_converter_unit.sv -----
// HSV to RGB converter, 8 bits per channel.
// Pipeline: an input transfer passes the stage 1 to 4 registers and the output registers before its result is offered.
// Throughput: one pixel per cycle; a stalled output freezes the whole pipe.
// Reset: synchronous, active low; clears the stage valid bits only, the
// datapath registers keep whatever they hold.
module hsv_to_rgb_converter_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hsv2rgb_hsv_if.sink   i_hsv,
    hsv2rgb_rgb_if.source o_rgb
);

    // One valid bit per pipeline stage, moving in lockstep with the data.
    logic [hsv2rgb_pkg::PIPE_DEPTH-1:0] r_vld, n_vld;
    logic                               w_advance;

    // The pipe moves whenever its last stage is empty or being taken.
    // With that rule nothing is dropped on a stall and nothing repeats,
    // and a new transfer is taken every cycle while the sink keeps up.
    assign w_advance = !r_vld[hsv2rgb_pkg::PIPE_DEPTH-1] || o_rgb.ready;

    assign i_hsv.ready = w_advance;
    assign o_rgb.valid = r_vld[hsv2rgb_pkg::PIPE_DEPTH-1];

    // Shift the valid bits in; the first one takes the input valid.
    always_comb begin
        n_vld = r_vld;
        if (w_advance) begin
            n_vld = {r_vld[hsv2rgb_pkg::PIPE_DEPTH-2:0], i_hsv.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Five stages: sector split, p/q/t numerators, scaling by value with a first guess of p,
    // p fix-up with a first guess of q and t, then q/t fix-up and channel selection.
    // Divides by 255 and 65025 use a shift-add estimate plus one correction.
    hsv2rgb_datapath u_datapath (
        .i_clk        (i_clk),
        .i_advance    (w_advance),
        .i_hue        (i_hsv.hue),
        .i_saturation (i_hsv.saturation),
        .i_value      (i_hsv.value),
        .o_red        (o_rgb.red),
        .o_green      (o_rgb.green),
        .o_blue       (o_rgb.blue)
    );

endmodule

// ----- rtl/hsv2rgb_checker.sv -----
`include "hsv_to_rgb_converter_unit_assert.svh"

module hsv2rgb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input hsv2rgb_pkg::t_chan i_red,
    input hsv2rgb_pkg::t_chan i_green,
    input hsv2rgb_pkg::t_chan i_blue
);

    logic                            w_stall;
    logic                            w_free;
    logic [3*hsv2rgb_pkg::CH_W-1:0]  w_rgb;

    assign w_stall = i_out_valid && !i_out_ready;
    assign w_free  = !i_out_valid || i_out_ready;
    assign w_rgb   = {i_red, i_green, i_blue};

    // Input is taken exactly when the output side can move.
    `HSV2RGB_ASSERT_RST(a_ready_follows_out, i_clk, i_rst_n, i_in_ready == w_free, "ready not free")

    // No result is offered right after reset.
    `HSV2RGB_ASSERT(a_empty_after_reset, i_clk, !i_rst_n |=> !i_out_valid, "valid after reset")

    // A stalled result stays offered.
    `HSV2RGB_ASSERT_RST(a_valid_holds, i_clk, i_rst_n, w_stall |=> i_out_valid, "valid dropped")

    // A stalled result keeps its payload.
    `HSV2RGB_ASSERT_RST(a_payload_holds, i_clk, i_rst_n, w_stall |=> $stable(w_rgb), "data moved")

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_hsv2rgb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_hsv.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);

// ----- tb/tb_hsv_to_rgb_converter_unit.sv -----
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter_unit;
    import hsv2rgb_pkg::*;

    // Abort when no transfer happens on either side for this many cycles.
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTED  = 10;
    localparam int HOLD_OFF_LONG = 200;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } rgb_pixel_t;

    logic clk;
    logic rst_n;

    hsv2rgb_hsv_if hsv_ch ();
    hsv2rgb_rgb_if rgb_ch ();

    hsv_to_rgb_converter_unit i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_hsv   (hsv_ch.sink),
        .o_rgb   (rgb_ch.source)
    );

    // Colors predicted for accepted pixels, oldest first.
    rgb_pixel_t rgb_pending_q[$];

    int src_idle_pct  = 0;    // chance in percent that the sender skips a cycle
    int snk_idle_pct  = 0;    // chance in percent that the receiver drops ready
    int hold_off_left = 0;    // cycles of forced receiver hold-off still to run
    int mismatch_cnt  = 0;
    int idle_cycles   = 0;

    // 100 MHz clock.
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Convert one pixel. Split the hue circle into six sectors, take the
    // position inside the sector as a fraction over 255, then build the three
    // intermediate levels with exact integer division (truncating).
    function automatic rgb_pixel_t hsv_to_rgb_color(input t_chan h, input t_chan s,
                                                    input t_chan v);
        int unsigned scaled;
        int unsigned sec_idx;
        int unsigned frac;
        int unsigned sat;
        int unsigned lvl;
        int unsigned p_lvl;
        int unsigned q_lvl;
        int unsigned t_lvl;
        t_sector     sec;
        rgb_pixel_t  pix;
        scaled  = SECTORS * int'(h);
        sec_idx = scaled / FULL;
        frac    = scaled - FULL * sec_idx;
        // Full-scale hue lands one past the last sector: wrap it to red.
        if (sec_idx >= SECTORS) begin
            sec_idx = sec_idx - SECTORS;
        end
        sec   = t_sector'(sec_idx);
        sat   = s;
        lvl   = v;
        p_lvl = (lvl * (FULL - sat)) / FULL;
        q_lvl = (lvl * (FULL_SQ - frac * sat)) / FULL_SQ;
        t_lvl = (lvl * (FULL_SQ - (FULL - frac) * sat)) / FULL_SQ;
        case (sec)
            SEC_RED_YEL: begin
                pix = {t_chan'(lvl), t_chan'(t_lvl), t_chan'(p_lvl)};
            end
            SEC_YEL_GRN: begin
                pix = {t_chan'(q_lvl), t_chan'(lvl), t_chan'(p_lvl)};
            end
            SEC_GRN_CYN: begin
                pix = {t_chan'(p_lvl), t_chan'(lvl), t_chan'(t_lvl)};
            end
            SEC_CYN_BLU: begin
                pix = {t_chan'(p_lvl), t_chan'(q_lvl), t_chan'(lvl)};
            end
            SEC_BLU_MAG: begin
                pix = {t_chan'(t_lvl), t_chan'(p_lvl), t_chan'(lvl)};
            end
            default: begin
                pix = {t_chan'(lvl), t_chan'(p_lvl), t_chan'(q_lvl)};
            end
        endcase
        return pix;
    endfunction

    // Record every input transfer and check every output transfer against the
    // oldest prediction. Both sides sample at the clock edge, before any
    // nonblocking update of that edge lands.
    always @(posedge clk) begin
        rgb_pixel_t got;
        rgb_pixel_t want;
        if (rst_n) begin
            if (hsv_ch.valid && hsv_ch.ready) begin
                rgb_pending_q.push_back(hsv_to_rgb_color(hsv_ch.hue, hsv_ch.saturation,
                                                         hsv_ch.value));
            end
            if (rgb_ch.valid && rgb_ch.ready) begin
                got = {rgb_ch.red, rgb_ch.green, rgb_ch.blue};
                if (rgb_pending_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTED) begin
                        $display("[%0t] unexpected color r=%0d g=%0d b=%0d", $realtime,
                                 got.red, got.green, got.blue);
                    end
                end else begin
                    want = rgb_pending_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTED) begin
                            $display("[%0t] mismatch: exp %0d %0d %0d, got %0d %0d %0d",
                                     $realtime, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer and end the run on a hang.
    always @(posedge clk) begin
        if ((hsv_ch.valid && hsv_ch.ready) || (rgb_ch.valid && rgb_ch.ready) || !rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: hold ready low while a forced hold-off is running, otherwise
    // drop it at random according to the current idle rate.
    initial begin
        rgb_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_off_left > 0) begin
                rgb_ch.ready <= 1'b0;
                hold_off_left = hold_off_left - 1;
            end else begin
                rgb_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Offer one pixel and hold it until the block takes it. Idle cycles before
    // the offer carry junk payload with valid low.
    task automatic send_pixel(input t_chan h, input t_chan s, input t_chan v);
        while ($urandom_range(99) < src_idle_pct) begin
            hsv_ch.valid      <= 1'b0;
            hsv_ch.hue        <= t_chan'($urandom);
            hsv_ch.saturation <= t_chan'($urandom);
            hsv_ch.value      <= t_chan'($urandom);
            @(posedge clk);
        end
        hsv_ch.valid      <= 1'b1;
        hsv_ch.hue        <= h;
        hsv_ch.saturation <= s;
        hsv_ch.value      <= v;
        do begin
            @(posedge clk);
        end while (!hsv_ch.ready);
    endtask

    // Favor the ends of the range so grey, black and fully saturated colors
    // show up often, but keep most levels uniform.
    function automatic t_chan pick_level();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return '0;
        end else if (roll < 16) begin
            return '1;
        end
        return t_chan'($urandom);
    endfunction

    // Corners: black, white, grey, the hue wrap at full scale, every sector
    // and the first hue of each sector, plus the hues just below 43, 213 and the wrap.
    task automatic test_directed_corners();
        t_chan sector_hues[14];
        sector_hues = '{8'd21, 8'd42, 8'd43, 8'd64, 8'd85, 8'd106, 8'd128,
                        8'd149, 8'd170, 8'd191, 8'd212, 8'd213, 8'd234, 8'd254};
        send_pixel(8'd0,   8'd0,   8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0,   8'd255, 8'd255);
        send_pixel(8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd0,   8'd128);
        send_pixel(8'd100, 8'd0,   8'd255);
        send_pixel(8'd170, 8'd200, 8'd0);
        foreach (sector_hues[i]) begin
            send_pixel(sector_hues[i], 8'd255, 8'd255);
        end
        send_pixel(8'd254, 8'd1,   8'd1);
        send_pixel(8'd1,   8'd254, 8'd254);
    endtask

    task automatic test_random_stream(input int n_pixels, input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (n_pixels) begin
            send_pixel(t_chan'($urandom), pick_level(), pick_level());
        end
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering, so the pipe fills and back-pressures its input.
    task automatic test_output_backpressure();
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        hold_off_left = HOLD_OFF_LONG;
        repeat (60) begin
            send_pixel(t_chan'($urandom), pick_level(), pick_level());
        end
    endtask

    // Stop offering, let every predicted color arrive, then watch for stray results.
    task automatic test_drain();
        hsv_ch.valid <= 1'b0;
        snk_idle_pct = 0;
        while (rgb_pending_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH * 4) @(posedge clk);
    endtask

    initial begin
        hsv_ch.valid      = 1'b0;
        hsv_ch.hue        = '0;
        hsv_ch.saturation = '0;
        hsv_ch.value      = '0;
        rst_n             = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 7;
        snk_idle_pct = 78;
        test_directed_corners();
        test_random_stream(450, 7, 78);
        test_random_stream(450, 78, 7);
        test_random_stream(450, 0, 0);
        test_output_backpressure();
        test_drain();

        if (mismatch_cnt == 0 && rgb_pending_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/hsv2rgb_pkg.sv
rtl/hsv2rgb_hsv_if.sv
rtl/hsv2rgb_rgb_if.sv
rtl/hsv2rgb_datapath.sv
rtl/hsv_to_rgb_converter_unit.sv
rtl/hsv2rgb_checker.sv
tb/tb_hsv_to_rgb_converter_unit.sv
